### design/crd_pkg.sv
// Shared constants and types for the camera ray direction core.
package crd_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 15;
  localparam int DIM_W      = 13;
  localparam int TAN_W      = 16;
  localparam int JIT_W      = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PX_W    = COORD_BITS + JIT_W + 1;
  localparam int DQ_W    = DIM_W + JIT_W;
  localparam int DIFF_W  = (PX_W > DQ_W) ? PX_W : DQ_W;
  localparam int PROD_W  = TAN_W + DIFF_W;
  localparam int A_SHIFT = 28;
  localparam int A_W     = DIM_W + A_SHIFT;
  localparam int MAG_W   = (PROD_W > A_W) ? PROD_W : A_W;
  localparam int POS_W   = $clog2(MAG_W);
  localparam int NORM_TOP = 30;
  localparam int NORM_W  = NORM_TOP + 1;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int ROOT_STAGES = ROOT_W;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int DIV_W   = ROOT_W + Q_W;

  localparam logic [JIT_W-1:0] HALF_OFS = JIT_W'(1) << (JIT_W - 1);
  localparam logic [FRAC_BITS-1:0] COMP_MAX = {FRAC_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TAN    = 2'd2,
    REG_JITTER = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NORM_W-1:0] a;
    logic [NORM_W-1:0] b;
    logic [NORM_W-1:0] c;
    logic              neg_y;
    logic              neg_z;
    logic              zero;
  } side_t;

endpackage

### design/crd_if.sv
// Request and response channel interfaces.
interface crd_req_if import crd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [JIT_W-1:0]      jitter_col;
  logic [JIT_W-1:0]      jitter_row;
  modport source(output valid, pixel_col, pixel_row, jitter_col, jitter_row, input ready);
  modport sink(input valid, pixel_col, pixel_row, jitter_col, jitter_row, output ready);
endinterface

interface crd_rsp_if import crd_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic [FRAC_BITS-1:0]        dir_forward;
  logic signed [FRAC_BITS:0]   dir_horizontal;
  logic signed [FRAC_BITS:0]   dir_vertical;
  modport source(output valid, dir_forward, dir_horizontal, dir_vertical, input ready);
  modport sink(input valid, dir_forward, dir_horizontal, dir_vertical, output ready);
endinterface

### design/crd_front.sv
// Front pipeline: offsets, tangent scaling, block normalization, sum of squares.
module crd_front import crd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [JIT_W-1:0]      jit_col_i,
  input  logic [JIT_W-1:0]      jit_row_i,
  input  logic [DIM_W-1:0]      width_i,
  input  logic [DIM_W-1:0]      height_i,
  input  logic [TAN_W-1:0]      tan_i,
  input  logic                  jit_en_i,
  output logic                  valid_o,
  output logic [SUM_W-1:0]      sum_o,
  output side_t                 side_o
);

  localparam int NST = 7;

  logic vld_q [NST];

  // stage 0
  logic [JIT_W-1:0]  f_ofs, g_ofs;
  logic [DIFF_W-1:0] px2, py2, wq, hq;
  logic [DIFF_W-1:0] ny_d, nz_d, ny_q, nz_q;
  logic              negy_d, negz_d;
  logic              negy0_q, negz0_q;

  assign f_ofs = jit_en_i ? jit_col_i : HALF_OFS;
  assign g_ofs = jit_en_i ? jit_row_i : HALF_OFS;
  assign px2 = DIFF_W'({col_i, f_ofs, 1'b0});
  assign py2 = DIFF_W'({row_i, g_ofs, 1'b0});
  assign wq  = DIFF_W'({width_i, {JIT_W{1'b0}}});
  assign hq  = DIFF_W'({height_i, {JIT_W{1'b0}}});
  assign negy_d = px2 > wq;
  assign negz_d = hq > py2;
  assign ny_d = negy_d ? px2 - wq : wq - px2;
  assign nz_d = negz_d ? hq - py2 : py2 - hq;

  // stage 1
  logic [MAG_W-1:0] a1_q, b1_q, c1_q;
  logic             negy1_q, negz1_q;

  // stage 2
  logic [MAG_W-1:0] a2_q, b2_q, c2_q, m2_q, m_d;
  logic             negy2_q, negz2_q;

  always_comb begin
    m_d = a1_q;
    if (b1_q > m_d) m_d = b1_q;
    if (c1_q > m_d) m_d = c1_q;
  end

  // stage 3
  logic [MAG_W-1:0] a3_q, b3_q, c3_q;
  logic [POS_W-1:0] pos_d, pos_q;
  logic             zero3_q, negy3_q, negz3_q;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m2_q[i]) pos_d = POS_W'(i);
    end
  end

  // stage 4
  function automatic logic [NORM_W-1:0] norm_shift(input logic [MAG_W-1:0] v,
                                                    input logic [POS_W-1:0] pos);
    logic [MAG_W-1:0] s;
    if (pos >= POS_W'(NORM_TOP)) s = v >> (pos - POS_W'(NORM_TOP));
    else s = v << (POS_W'(NORM_TOP) - pos);
    return s[NORM_W-1:0];
  endfunction

  side_t side4_q, side5_q, side6_q;

  // stage 5
  logic [SQ_W-1:0] sqa_q, sqb_q, sqc_q;

  // stage 6
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ny_q    <= ny_d;
      nz_q    <= nz_d;
      negy0_q <= negy_d;
      negz0_q <= negz_d;

      a1_q    <= MAG_W'({width_i, {A_SHIFT{1'b0}}});
      b1_q    <= MAG_W'(tan_i * ny_q);
      c1_q    <= MAG_W'(tan_i * nz_q);
      negy1_q <= negy0_q;
      negz1_q <= negz0_q;

      a2_q    <= a1_q;
      b2_q    <= b1_q;
      c2_q    <= c1_q;
      m2_q    <= m_d;
      negy2_q <= negy1_q;
      negz2_q <= negz1_q;

      a3_q    <= a2_q;
      b3_q    <= b2_q;
      c3_q    <= c2_q;
      pos_q   <= pos_d;
      zero3_q <= (m2_q == '0);
      negy3_q <= negy2_q;
      negz3_q <= negz2_q;

      side4_q.a     <= norm_shift(a3_q, pos_q);
      side4_q.b     <= norm_shift(b3_q, pos_q);
      side4_q.c     <= norm_shift(c3_q, pos_q);
      side4_q.neg_y <= negy3_q;
      side4_q.neg_z <= negz3_q;
      side4_q.zero  <= zero3_q;

      sqa_q   <= side4_q.a * side4_q.a;
      sqb_q   <= side4_q.b * side4_q.b;
      sqc_q   <= side4_q.c * side4_q.c;
      side5_q <= side4_q;

      sum_q   <= SUM_W'(sqa_q) + SUM_W'(sqb_q) + SUM_W'(sqc_q);
      side6_q <= side5_q;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign sum_o   = sum_q;
  assign side_o  = side6_q;

endmodule

### design/crd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module crd_isqrt import crd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic             vld_q  [ROOT_STAGES];
  logic [SUM_W-1:0] v_q    [ROOT_STAGES];
  logic [SUM_W-1:0] res_q  [ROOT_STAGES];
  side_t            side_q [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_st
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic             vi;
    logic [SUM_W-1:0] v_in, res_in, trial, v_d, res_d;
    side_t            s_in;

    if (k == 0) begin : g_first
      assign vi     = valid_i;
      assign v_in   = sum_i;
      assign res_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign vi     = vld_q[k-1];
      assign v_in   = v_q[k-1];
      assign res_in = res_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign trial = res_in + BIT;

    always_comb begin
      if (v_in >= trial) begin
        v_d   = v_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        v_d   = v_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_d;
        res_q[k]  <= res_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_STAGES-1];
  assign root_o  = res_q[ROOT_STAGES-1][ROOT_W-1:0];
  assign side_o  = side_q[ROOT_STAGES-1];

  // normalized sum is at least 2^60, so the root has a top bit set
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.zero |-> root_o[ROOT_W-1:NORM_TOP] != '0)
    else $error("root below normalized range");

endmodule

### design/crd_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
module crd_div import crd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] root_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    q_o [3],
  output side_t             side_o
);

  logic              vld_q  [Q_W];
  logic [ROOT_W-1:0] root_q [Q_W];
  logic [DIV_W-1:0]  rem_q  [Q_W][3];
  logic [Q_W-1:0]    quo_q  [Q_W][3];
  side_t             side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int QB = Q_W - 1 - k;
    logic              vi;
    logic [ROOT_W-1:0] r_in;
    logic [DIV_W-1:0]  rem_in [3];
    logic [Q_W-1:0]    quo_in [3];
    logic [DIV_W-1:0]  rem_d  [3];
    logic [Q_W-1:0]    quo_d  [3];
    logic [DIV_W-1:0]  dsh;
    side_t             s_in;

    if (k == 0) begin : g_first
      assign vi        = valid_i;
      assign r_in      = root_i;
      assign s_in      = side_i;
      assign rem_in[0] = DIV_W'({side_i.a, {FRAC_BITS{1'b0}}});
      assign rem_in[1] = DIV_W'({side_i.b, {FRAC_BITS{1'b0}}});
      assign rem_in[2] = DIV_W'({side_i.c, {FRAC_BITS{1'b0}}});
      assign quo_in[0] = '0;
      assign quo_in[1] = '0;
      assign quo_in[2] = '0;
    end else begin : g_next
      assign vi     = vld_q[k-1];
      assign r_in   = root_q[k-1];
      assign s_in   = side_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign dsh = DIV_W'(r_in) << QB;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (rem_in[l] >= dsh) begin
          rem_d[l]     = rem_in[l] - dsh;
          quo_d[l][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= r_in;
        side_q[k] <= s_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign q_o     = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

  // each component is at most the norm, so the quotient never passes one
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.zero |-> q_o[0] <= (Q_W'(1) << FRAC_BITS)
                              && q_o[1] <= (Q_W'(1) << FRAC_BITS)
                              && q_o[2] <= (Q_W'(1) << FRAC_BITS))
    else $error("quotient above unit");

endmodule

### design/camera_ray_direction_core.sv
// Top level: config registers, pipeline stages and response register.
// Pipeline: front, square root and divide stages, then the response register.
// Throughput: one request per cycle; a stalled response holds the whole pipeline.
// Reset: async active low clears valid bits and restores width 640, height 480,
// tangent 1.0 (Q4.12) and jitter off; no clearing pass.
module camera_ray_direction_core import crd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  crd_req_if.sink               req_i,
  crd_rsp_if.source             rsp_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [TAN_W-1:0] tan_q;
  logic             jit_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      tan_q    <= TAN_W'(4096);
      jit_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_TAN:    tan_q    <= cfg_data_i[TAN_W-1:0];
        REG_JITTER: jit_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  logic             fr_vld, sq_vld, dv_vld;
  logic [SUM_W-1:0] fr_sum;
  side_t            fr_side, sq_side, dv_side;
  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]   quo [3];

  crd_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(req_i.valid),
    .col_i(req_i.pixel_col), .row_i(req_i.pixel_row),
    .jit_col_i(req_i.jitter_col), .jit_row_i(req_i.jitter_row),
    .width_i(width_q), .height_i(height_q), .tan_i(tan_q), .jit_en_i(jit_en_q),
    .valid_o(fr_vld), .sum_o(fr_sum), .side_o(fr_side)
  );

  crd_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(fr_vld), .sum_i(fr_sum), .side_i(fr_side),
    .valid_o(sq_vld), .root_o(root), .side_o(sq_side)
  );

  crd_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sq_vld), .root_i(root), .side_i(sq_side),
    .valid_o(dv_vld), .q_o(quo), .side_o(dv_side)
  );

  function automatic logic [FRAC_BITS-1:0] sat(input logic [Q_W-1:0] q);
    return (q > Q_W'(COMP_MAX)) ? COMP_MAX : q[FRAC_BITS-1:0];
  endfunction

  logic [FRAC_BITS-1:0] fwd_d, hs, vs;
  logic [FRAC_BITS:0]   hor_d, ver_d;
  logic [FRAC_BITS-1:0] fwd_q;
  logic [FRAC_BITS:0]   hor_q, ver_q;

  always_comb begin
    hs    = sat(quo[1]);
    vs    = sat(quo[2]);
    fwd_d = sat(quo[0]);
    hor_d = dv_side.neg_y ? -{1'b0, hs} : {1'b0, hs};
    ver_d = dv_side.neg_z ? -{1'b0, vs} : {1'b0, vs};
    if (dv_side.zero) begin
      fwd_d = COMP_MAX;
      hor_d = '0;
      ver_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_q <= fwd_d;
      hor_q <= hor_d;
      ver_q <= ver_d;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.dir_forward    = fwd_q;
  assign rsp_o.dir_horizontal = hor_q;
  assign rsp_o.dir_vertical   = ver_q;

  // saturation keeps negative components off the most negative code
  a_hor_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.dir_horizontal != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("horizontal reached most negative code");

  a_ver_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.dir_vertical != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("vertical reached most negative code");

endmodule

### verif/crd_tb_if.sv
// Testbench-side note: channel interfaces come from the design files; this file holds shared tb types.
package crd_tb_pkg;
  import crd_pkg::*;

  typedef struct packed {
    logic [FRAC_BITS-1:0]      fwd;
    logic signed [FRAC_BITS:0] hor;
    logic signed [FRAC_BITS:0] ver;
  } ray_dir_t;
endpackage

### verif/crd_checker.sv
// Checker: predicts ray directions from observed requests and config writes, compares responses.
module crd_checker import crd_pkg::*; import crd_tb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  crd_req_if.sink               req_mon,
  crd_rsp_if.sink               rsp_mon,
  output int                    err_cnt_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DIM_W-1:0] width_q, height_q;
  logic [TAN_W-1:0] tan_q;
  logic             jit_q;
  ray_dir_t         dir_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] unit_comp(logic [63:0] mag, logic [63:0] r);
    logic [63:0] q;
    q = (mag << FRAC_BITS) / r;
    return (q > 64'(COMP_MAX)) ? 64'(COMP_MAX) : q;
  endfunction

  function automatic ray_dir_t ray_direction(logic [11:0] col, logic [11:0] row,
                                             logic [15:0] jc, logic [15:0] jr);
    logic [63:0] f, g, px, py, wq, hq, ny, nz, a, b, c, m, r, fv, hv, vv;
    logic        yn, zn;
    ray_dir_t    d;
    f = jit_q ? 64'(jc) : 64'd32768;
    g = jit_q ? 64'(jr) : 64'd32768;
    px = (64'(col) << 16) + f;
    py = (64'(row) << 16) + g;
    wq = 64'(width_q) << 16;
    hq = 64'(height_q) << 16;
    yn = (px << 1) > wq;
    ny = yn ? (px << 1) - wq : wq - (px << 1);
    zn = hq > (py << 1);
    nz = zn ? hq - (py << 1) : (py << 1) - hq;
    a = 64'(width_q) << 28;
    b = 64'(tan_q) * ny;
    c = 64'(tan_q) * nz;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (m == 0) begin
      d.fwd = COMP_MAX;
      d.hor = '0;
      d.ver = '0;
      return d;
    end
    while (m >= (64'd1 << 31)) begin
      m >>= 1; a >>= 1; b >>= 1; c >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1; a <<= 1; b <<= 1; c <<= 1;
    end
    r = int_sqrt(a * a + b * b + c * c);
    fv = unit_comp(a, r);
    hv = unit_comp(b, r);
    vv = unit_comp(c, r);
    if (yn) hv = 64'd0 - hv;
    if (zn) vv = 64'd0 - vv;
    d.fwd = fv[FRAC_BITS-1:0];
    d.hor = hv[FRAC_BITS:0];
    d.ver = vv[FRAC_BITS:0];
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ray_dir_t e;
    if (!rst_ni) begin
      width_q <= 13'd640;
      height_q <= 13'd480;
      tan_q <= 16'd4096;
      jit_q <= 1'b0;
      err_cnt_o <= 0;
      pending_o <= 0;
      dir_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        dir_q.push_back(ray_direction(req_mon.pixel_col, req_mon.pixel_row,
                                      req_mon.jitter_col, req_mon.jitter_row));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (dir_q.size() == 0) begin
          if (err_cnt_o < 10) $display("ERROR: response with no request pending");
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          e = dir_q.pop_front();
          if (e.fwd !== rsp_mon.dir_forward || e.hor !== rsp_mon.dir_horizontal ||
              e.ver !== rsp_mon.dir_vertical) begin
            if (err_cnt_o < 10)
              $display("ERROR: exp fwd=%0d hor=%0d ver=%0d got fwd=%0d hor=%0d ver=%0d",
                       e.fwd, e.hor, e.ver, rsp_mon.dir_forward,
                       rsp_mon.dir_horizontal, rsp_mon.dir_vertical);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      pending_o <= dir_q.size();
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WIDTH:  width_q <= cfg_data_i[DIM_W-1:0];
          REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          REG_TAN:    tan_q <= cfg_data_i[TAN_W-1:0];
          REG_JITTER: jit_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

### verif/testbench.sv
// Testbench top: clock, reset, config phases, request stimulus and verdict.
module testbench import crd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 56;
  localparam int WDOG_LIMIT = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    err_cnt, pending, idle_cycles;
  int                    req_idle_pct = 0, rsp_stall_pct = 0;
  bit                    done = 0;

  crd_req_if req();
  crd_rsp_if rsp();

  camera_ray_direction_core dut(.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
                                .req_i(req.sink), .rsp_o(rsp.source));
  crd_checker chk(.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
                  .req_mon(req.sink), .rsp_mon(rsp.sink),
                  .err_cnt_o(err_cnt), .pending_o(pending));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.pixel_col = '0;
    req.pixel_row = '0;
    req.jitter_col = '0;
    req.jitter_row = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk_i)
    rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Hold a request until accepted; idle gaps inserted before it.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] jc,
                            logic [15:0] jr);
    while ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.pixel_col <= col;
    req.pixel_row <= row;
    req.jitter_col <= jc;
    req.jitter_row <= jr;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic end_burst();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_burst(int n, int w);
    logic [11:0] c, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: c = 12'($urandom);
        1: c = 12'($urandom_range(w > 0 ? w - 1 : 0));
        2: c = 12'($urandom_range(1) ? 0 : 4095);
        default: c = 12'($urandom_range(w / 2 + 2, w / 2 > 2 ? w / 2 - 2 : 0));
      endcase
      r = ($urandom_range(3) == 0) ? 12'($urandom_range(1) ? 0 : 4095) : 12'($urandom);
      send_pixel(c, r, 16'($urandom), 16'($urandom));
    end
    end_burst();
  endtask

  initial begin
    int w;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed at reset config: corners, center, jitter ignored
    send_pixel(0, 0, 16'hFFFF, 0);
    send_pixel(4095, 4095, 0, 16'hFFFF);
    send_pixel(319, 239, 16'h1234, 16'hABCD);
    send_pixel(639, 479, 0, 0);
    end_burst();
    drain();

    // jitter extremes, saturating tangent
    write_reg(REG_JITTER, 1);
    write_reg(REG_TAN, 16'hFFFF);
    send_pixel(0, 0, 0, 0);
    send_pixel(0, 0, 16'hFFFF, 16'hFFFF);
    send_pixel(4095, 4095, 16'hFFFF, 16'hFFFF);
    send_pixel(320, 240, 0, 0);
    send_pixel(2048, 2048, 16'h8000, 16'h8000);
    end_burst();
    drain();

    // zero width and zero tangent: zero vector case; then tangent 1.0 at zero width
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    write_reg(REG_TAN, 0);
    send_pixel(0, 0, 0, 0);
    send_pixel(100, 100, 16'h5555, 16'hAAAA);
    end_burst();
    drain();
    write_reg(REG_TAN, 16'd4096);
    send_pixel(0, 0, 0, 0);
    send_pixel(4095, 0, 16'hFFFF, 0);
    end_burst();
    drain();

    // wide register values, max range
    write_reg(REG_WIDTH, 16'hFFFF);
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_TAN, 16'd1);
    send_pixel(4095, 4095, 16'hFFFF, 16'hFFFF);
    send_pixel(0, 0, 0, 0);
    end_burst();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 85; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 85; end
        default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
      endcase
      case (ph)
        0: w = 1;
        1: w = 4096;
        2: w = 8191;
        default: w = $urandom_range(1, 4096);
      endcase
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 4096)));
      write_reg(REG_TAN, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'd0 : 16'($urandom));
      write_reg(REG_JITTER, 16'($urandom_range(1)));
      random_burst(56, w > 4095 ? 4095 : w);
      drain();
    end

    done = 1;
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
